// File: rtl/core/jas_pkg.sv
// shared constants, types and helpers of the joystick axis scaler
`default_nettype none

package jas_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int CENTER_W   = 10;
	localparam int MAX_W      = 11;
	localparam int LIMIT_W    = 10;
	localparam int OUT_W      = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam int FULL_SCALE = 255;
	localparam int OUT_LIMIT  = 255;
	localparam int LIMIT      = (FULL_SCALE < OUT_LIMIT) ? FULL_SCALE : OUT_LIMIT;
	localparam int MAG_W      = OUT_W - 1;

	// dividend is distance times full scale, quotient is produced one bit per cycle
	localparam int FS_W  = $clog2(FULL_SCALE + 1);
	localparam int DVD_W = SAMPLE_W + FS_W;
	localparam int DIV_W = MAX_W;
	localparam int REM_W = DIV_W + 1;
	localparam int CNT_W = $clog2(DVD_W);

	localparam logic [CENTER_W-1:0] CENTER_RST     = CENTER_W'(512);
	localparam logic [MAX_W-1:0]    MAX_RST        = MAX_W'(1024);
	localparam logic [LIMIT_W-1:0]  MIN_CHANGE_RST = LIMIT_W'(5);
	localparam logic [LIMIT_W-1:0]  DEAD_ZONE_RST  = LIMIT_W'(20);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER     = 3'd0,
		REG_MAX        = 3'd1,
		REG_INVERT     = 3'd2,
		REG_MIN_CHANGE = 3'd3,
		REG_DEAD_ZONE  = 3'd4
	} jas_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} jas_state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic step;
		logic finish;
	} jas_cmd_t;

	typedef struct packed {
		logic need_div;
	} jas_sts_t;

	function automatic logic signed [OUT_W-1:0] signed_value(
		input logic [MAG_W-1:0] mag,
		input logic             neg
	);
		logic signed [OUT_W-1:0] v;
		v = $signed({1'b0, mag});
		return neg ? -v : v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/jas_ctrl.sv
// sequencer of the joystick axis scaler: handshakes and divider step count
`default_nettype none

module jas_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output jas_pkg::jas_cmd_t  cmd,
	input  wire jas_pkg::jas_sts_t sts
);
	import jas_pkg::*;

	jas_state_t       state_q;
	jas_state_t       state_d;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.need_div ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < CNT_W'(DVD_W))
		else $error("divider ran past its step count");
	a_no_div_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && !sts.need_div) |=> state_q == ST_OUT)
		else $error("item without division did not go to output");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result item dropped while stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/core/jas_dpath.sv
// datapath of the joystick axis scaler: config, classification, divider, result
`default_nettype none

module jas_dpath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [jas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [jas_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [jas_pkg::SAMPLE_W-1:0]    sample,
	output logic signed [jas_pkg::OUT_W-1:0]     axis_value,
	output logic                                 updated,
	input  wire jas_pkg::jas_cmd_t               cmd,
	output jas_pkg::jas_sts_t                    sts
);
	import jas_pkg::*;

	logic [CENTER_W-1:0]     center_q;
	logic [MAX_W-1:0]        max_q;
	logic                    invert_q;
	logic [LIMIT_W-1:0]      min_change_q;
	logic [LIMIT_W-1:0]      dead_zone_q;

	logic [SAMPLE_W-1:0]     pos_q;
	logic [SAMPLE_W-1:0]     last_pos_q;
	logic                    have_q;
	logic signed [OUT_W-1:0] value_q;
	logic                    updated_q;

	logic [REM_W-1:0]        rem_q;
	logic [DVD_W-1:0]        quo_q;
	logic [DIV_W-1:0]        div_q;
	logic                    neg_q;

	logic [SAMPLE_W-1:0]     change;
	logic                    accept;
	logic                    above;
	logic                    below;
	logic [SAMPLE_W-1:0]     offset;
	logic                    dead;
	logic                    hit;
	logic signed [MAX_W:0]   range_up;
	logic                    rng_neg;
	logic [DIV_W-1:0]        rng_abs;
	logic [DIV_W-1:0]        divisor;
	logic                    neg;
	logic                    need_div;
	logic [DVD_W-1:0]        dividend;
	logic [MAG_W-1:0]        direct_mag;

	logic [REM_W-1:0]        rem_sh;
	logic                    rem_ge;
	logic [MAG_W-1:0]        quo_mag;

	// acceptance and region of the captured sample
	always_comb begin
		change   = (pos_q > last_pos_q) ? pos_q - last_pos_q : last_pos_q - pos_q;
		accept   = !have_q || (change > min_change_q);
		above    = pos_q > center_q;
		below    = pos_q < center_q;
		offset   = above ? pos_q - center_q : center_q - pos_q;
		dead     = offset < dead_zone_q;
		hit      = accept && (dead || above || below);
		range_up = $signed({1'b0, max_q}) - $signed({2'b0, center_q});
		rng_neg  = range_up[MAX_W];
		rng_abs  = rng_neg ? DIV_W'(-range_up) : range_up[DIV_W-1:0];
		divisor  = above ? rng_abs : DIV_W'(center_q);
		neg      = (below ^ (above && rng_neg)) ^ invert_q;
		need_div = hit && !dead && (divisor != '0);
		dividend = DVD_W'(offset) * DVD_W'(FULL_SCALE);
		direct_mag = dead ? '0 : MAG_W'(LIMIT);
	end

	// one restoring division step
	always_comb begin
		rem_sh  = {rem_q[REM_W-2:0], quo_q[DVD_W-1]};
		rem_ge  = rem_sh >= REM_W'(div_q);
		quo_mag = (quo_q > DVD_W'(LIMIT)) ? MAG_W'(LIMIT) : quo_q[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q     <= CENTER_RST;
			max_q        <= MAX_RST;
			invert_q     <= 1'b0;
			min_change_q <= MIN_CHANGE_RST;
			dead_zone_q  <= DEAD_ZONE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CENTER:     center_q     <= cfg_data[CENTER_W-1:0];
				REG_MAX:        max_q        <= cfg_data[MAX_W-1:0];
				REG_INVERT:     invert_q     <= cfg_data[0];
				REG_MIN_CHANGE: min_change_q <= cfg_data[LIMIT_W-1:0];
				REG_DEAD_ZONE:  dead_zone_q  <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= '0;
			have_q     <= 1'b0;
			value_q    <= '0;
			updated_q  <= 1'b0;
		end else if (cmd.eval) begin
			if (!hit) begin
				updated_q <= 1'b0;
			end else if (!need_div) begin
				value_q    <= signed_value(direct_mag, neg);
				last_pos_q <= pos_q;
				have_q     <= 1'b1;
				updated_q  <= 1'b1;
			end
		end else if (cmd.finish) begin
			value_q    <= signed_value(quo_mag, neg_q);
			last_pos_q <= pos_q;
			have_q     <= 1'b1;
			updated_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= sample;
		end
		if (cmd.eval) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
			neg_q <= neg;
		end else if (cmd.step) begin
			rem_q <= rem_ge ? rem_sh - REM_W'(div_q) : rem_sh;
			quo_q <= {quo_q[DVD_W-2:0], rem_ge};
		end
	end

	assign sts.need_div = need_div;
	assign axis_value   = value_q;
	assign updated      = updated_q;

`ifndef ASSERT_OFF
	a_finish_updates: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> updated_q && have_q)
		else $error("finished division did not commit the item");
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		value_q != $signed({1'b1, {(OUT_W-1){1'b0}}}))
		else $error("axis value outside the saturation range");
	a_have_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(have_q))
		else $error("position flag cleared outside reset");
`endif

endmodule

`default_nettype wire

// File: rtl/core/joystick_axis_scaler.sv
// top level of the joystick axis scaler
`default_nettype none

// Turns 10-bit converter samples into a signed axis value in -255..255 with
// a dead zone, a minimum-change filter, separate positive and negative spans
// and optional inversion. Every input item gives one result item carrying
// the current value and whether this sample updated it. Items are handled
// one at a time: a sample that is filtered out, falls in the dead zone or
// sees a zero span goes from evaluation straight to the result; any other
// first passes through the 18-step bit-serial divider that forms
// distance * 255 / span. A new item is taken in the cycle after the result
// leaves. Configuration writes take effect at once and are meant for idle.
module joystick_axis_scaler (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [jas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [jas_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [jas_pkg::SAMPLE_W-1:0]    sample,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [jas_pkg::OUT_W-1:0]     axis_value,
	output logic                                 updated
);
	import jas_pkg::*;

	jas_cmd_t cmd;
	jas_sts_t sts;

	jas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	jas_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.axis_value (axis_value),
		.updated    (updated),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

`default_nettype wire
